// ----- src/tpbt_pkg.sv -----
// Shared types, codes and defaults for the tagged pointer bounds table.
`default_nettype none
package tpbt_pkg;

  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned TagShiftDefault     = 48;

  localparam int unsigned PtrW  = 64;
  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_CHECK   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_UNTAGGED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_INUSE = 3'd4
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the accepted word
    logic mem_read;  // read the table at the selected slot
    logic execute;   // evaluate, update state, load the result register
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- src/tpbt_ctrl.sv -----
// Controller state machine: accept, table read, execute, result handshake.
`default_nettype none
module tpbt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tpbt_pkg::dp_cmd_t     cmd
);
  import tpbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.mem_read = 1'b0;
    cmd.execute  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/tpbt_datapath.sv -----
// Datapath: object table memories, free list head and result register.
`default_nettype none
module tpbt_datapath #(
  parameter int unsigned TABLE_ENTRIES = tpbt_pkg::TableEntriesDefault,
  parameter int unsigned TAG_SHIFT     = tpbt_pkg::TagShiftDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tpbt_pkg::dp_cmd_t             cmd,
  input  wire logic [1:0]                    opcode,
  input  wire logic [tpbt_pkg::PtrW-1:0]     tagged_pointer,
  input  wire logic [tpbt_pkg::AddrW-1:0]    new_base,
  input  wire logic [tpbt_pkg::AddrW-1:0]    object_size,
  output logic [tpbt_pkg::PtrW-1:0]          result_pointer,
  output logic [2:0]                         status_code,
  output logic                               in_bounds,
  output logic                               base_mismatch
);
  import tpbt_pkg::*;

  localparam int unsigned SlotW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LinkW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TagW  = PtrW - TAG_SHIFT;

  logic [1:0]       op_r;
  logic [PtrW-1:0]  ptr_r;
  logic [AddrW-1:0] nbase_r;
  logic [AddrW-1:0] osize_r;

  // head of the free list; fresh counts slots ever handed out in order
  logic [LinkW-1:0] head, head_next;
  logic [LinkW-1:0] fresh, fresh_next;

  logic [LinkW-1:0] link_mem [TABLE_ENTRIES];
  logic             use_mem  [TABLE_ENTRIES];
  logic [AddrW-1:0] base_mem [TABLE_ENTRIES];
  logic [AddrW-1:0] len_mem  [TABLE_ENTRIES];

  logic [SlotW-1:0] rd_addr;
  logic [LinkW-1:0] rd_link;
  logic             rd_use;
  logic [AddrW-1:0] rd_base;
  logic [AddrW-1:0] rd_len;

  logic [TagW-1:0]  tag;
  logic             tag_ok;
  logic [SlotW-1:0] slot;
  logic [PtrW-1:0]  addr;
  logic [SlotW-1:0] sel_addr;
  logic             full;
  logic             slot_used;
  logic [AddrW:0]   obj_end;

  logic             we_link, we_use, we_obj;
  logic             use_wdata;
  logic [PtrW-1:0]  res;
  status_t          status;
  logic             inb, mism;

  assign tag      = ptr_r[PtrW-1:TAG_SHIFT];
  assign tag_ok   = (tag != '0) && (PtrW'(tag) <= PtrW'(TABLE_ENTRIES));
  assign slot     = SlotW'(tag - TagW'(1));
  assign addr     = {{TagW{ptr_r[TAG_SHIFT-1]}}, ptr_r[TAG_SHIFT-1:0]};
  assign sel_addr = (opcode_t'(op_r) == OP_ALLOC) ? head[SlotW-1:0] : slot;
  assign full     = (head >= LinkW'(TABLE_ENTRIES));
  // entries at or above the fill count were never allocated
  assign slot_used = (LinkW'(rd_addr) < fresh) && rd_use;
  assign obj_end   = {1'b0, rd_base} + {1'b0, rd_len};

  function automatic logic [PtrW-1:0] make_tagged(logic [AddrW-1:0] b, logic [SlotW-1:0] s);
    logic [PtrW-1:0] t;
    t = PtrW'(s) + PtrW'(1);
    return PtrW'(b) | (t << TAG_SHIFT);
  endfunction

  always_comb begin
    head_next  = head;
    fresh_next = fresh;
    we_link    = 1'b0;
    we_use     = 1'b0;
    we_obj     = 1'b0;
    use_wdata  = 1'b0;
    res        = '0;
    status     = ST_OK;
    inb        = 1'b0;
    mism       = 1'b0;
    unique case (opcode_t'(op_r))
      OP_ALLOC: begin
        if (full) begin
          res    = PtrW'(nbase_r);
          status = ST_FULL;
        end else begin
          if (head == fresh) begin
            head_next  = head + LinkW'(1);
            fresh_next = fresh + LinkW'(1);
          end else begin
            head_next = rd_link;
          end
          we_use    = 1'b1;
          use_wdata = 1'b1;
          we_obj    = 1'b1;
          res       = make_tagged(nbase_r, rd_addr);
        end
      end
      OP_FREE: begin
        if (tag == '0) begin
          res    = ptr_r;
          status = ST_UNTAGGED;
        end else if (!tag_ok) begin
          res    = addr;
          status = ST_RANGE;
        end else if (!slot_used) begin
          res    = addr;
          status = ST_NOT_INUSE;
        end else begin
          we_use    = 1'b1;
          we_link   = 1'b1;
          head_next = LinkW'(rd_addr);
          res       = addr;
        end
      end
      OP_REALLOC: begin
        if (tag == '0) begin
          res    = PtrW'(nbase_r);
          status = ST_UNTAGGED;
        end else if (!tag_ok) begin
          res    = addr;
          status = ST_RANGE;
        end else if (!slot_used) begin
          res    = PtrW'(nbase_r);
          status = ST_NOT_INUSE;
        end else begin
          mism   = (PtrW'(rd_base) != addr);
          we_obj = 1'b1;
          res    = make_tagged(nbase_r, rd_addr);
        end
      end
      OP_CHECK: begin
        if (tag == '0) begin
          res    = ptr_r;
          status = ST_UNTAGGED;
        end else if (!tag_ok) begin
          res    = addr;
          status = ST_RANGE;
        end else begin
          res = addr;
          inb = (addr >= PtrW'(rd_base)) && (addr < PtrW'(obj_end));
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      ptr_r   <= tagged_pointer;
      nbase_r <= new_base;
      osize_r <= object_size;
    end
    if (cmd.mem_read) begin
      rd_addr <= sel_addr;
      rd_link <= link_mem[sel_addr];
      rd_use  <= use_mem[sel_addr];
      rd_base <= base_mem[sel_addr];
      rd_len  <= len_mem[sel_addr];
    end
    if (cmd.execute) begin
      if (we_link) link_mem[rd_addr] <= head;
      if (we_use)  use_mem[rd_addr]  <= use_wdata;
      if (we_obj) begin
        base_mem[rd_addr] <= nbase_r;
        len_mem[rd_addr]  <= osize_r;
      end
      result_pointer <= res;
      status_code    <= status;
      in_bounds      <= inb;
      base_mismatch  <= mism;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fresh <= '0;
    end else if (cmd.execute) begin
      head  <= head_next;
      fresh <= fresh_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/tagged_pointer_bounds_table.sv -----
// Top level of the tagged pointer bounds table.
// A result follows the edge that accepts its word through the registered read of the
// slot table (S_READ) and the evaluate and write-back step (S_EXEC). Input ready
// returns in the same cycle that the result becomes valid. One word is in flight
// at a time, and a waiting result stalls the execute step until it is taken. The
// table has no clearing pass after reset: a fill count marks the slots never handed
// out, so the block is ready at once. Slot numbers plus one travel as tags in pointer
// bits from TAG_SHIFT upward.
`default_nettype none
module tagged_pointer_bounds_table #(
  parameter int unsigned TABLE_ENTRIES = tpbt_pkg::TableEntriesDefault,
  parameter int unsigned TAG_SHIFT     = tpbt_pkg::TagShiftDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 opcode,
  input  wire logic [tpbt_pkg::PtrW-1:0]  tagged_pointer,
  input  wire logic [tpbt_pkg::AddrW-1:0] new_base,
  input  wire logic [tpbt_pkg::AddrW-1:0] object_size,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tpbt_pkg::PtrW-1:0]       result_pointer,
  output logic [2:0]                      status_code,
  output logic                            in_bounds,
  output logic                            base_mismatch
);
  import tpbt_pkg::*;

  dp_cmd_t cmd;

  tpbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tpbt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TAG_SHIFT     (TAG_SHIFT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (opcode),
    .tagged_pointer (tagged_pointer),
    .new_base       (new_base),
    .object_size    (object_size),
    .result_pointer (result_pointer),
    .status_code    (status_code),
    .in_bounds      (in_bounds),
    .base_mismatch  (base_mismatch)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while another is in flight");

  a_exec_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_inb_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_bounds) |-> (status_code == ST_OK))
    else $error("in_bounds set on a failed check");

  a_mism_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && base_mismatch) |-> (status_code == ST_OK))
    else $error("base_mismatch set on a failed reallocate");

endmodule
`default_nettype wire

// ----- sim/tb_tagged_pointer_bounds_table.sv -----
// Testbench for the tagged pointer bounds table: random and directed words, scoreboard check.
`default_nettype none
module tb_tagged_pointer_bounds_table;
  timeunit 1ns;
  timeprecision 1ps;
  import tpbt_pkg::*;

  localparam int unsigned NSLOTS = 256;
  localparam int unsigned TSHIFT = 48;

  typedef struct packed {
    opcode_t     op;
    logic [63:0] ptr;
    logic [47:0] base;
    logic [47:0] size;
  } request_t;

  typedef struct packed {
    logic [63:0] ptr;
    status_t     status;
    logic        inb;
    logic        mism;
  } answer_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [1:0] opcode = '0;
  logic [63:0] tagged_pointer = '0;
  logic [47:0] new_base = '0, object_size = '0;
  logic in_ready, out_valid, in_bounds, base_mismatch;
  logic [63:0] result_pointer;
  logic [2:0] status_code;

  tagged_pointer_bounds_table u_dut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .tagged_pointer, .new_base,
    .object_size, .out_valid, .out_ready, .result_pointer, .status_code,
    .in_bounds, .base_mismatch
  );

  // predictor copy of the table
  int unsigned head;
  int unsigned link_of [NSLOTS];
  bit          busy [NSLOTS];
  logic [47:0] rec_base [NSLOTS];
  logic [47:0] rec_len [NSLOTS];
  bit          written [NSLOTS];

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0, hold_off = 0;
  bit all_sent = 0;

  // acceptance seen at the rising edge, used by the sender at the next falling edge
  logic in_ready_q = 0;

  function automatic logic [63:0] strip_tag(logic [63:0] p);
    return {{16{p[47]}}, p[47:0]};
  endfunction

  function automatic answer_t table_step(request_t r);
    answer_t a;
    logic [63:0] tag, addr, lim;
    int unsigned s;
    bit ok;
    a = '{ptr: '0, status: ST_OK, inb: 0, mism: 0};
    tag = r.ptr >> TSHIFT;
    addr = strip_tag(r.ptr);
    ok = tag >= 1 && tag <= NSLOTS;
    s = ok ? 32'(tag - 1) : 0;
    case (r.op)
      OP_ALLOC: begin
        if (head >= NSLOTS) begin
          a.ptr = {16'h0, r.base};
          a.status = ST_FULL;
        end else begin
          s = head;
          head = link_of[s];
          busy[s] = 1;
          written[s] = 1;
          rec_base[s] = r.base;
          rec_len[s] = r.size;
          a.ptr = {16'(s + 1), r.base};
        end
      end
      OP_FREE: begin
        a.ptr = addr;
        if (tag == 0) begin
          a.ptr = r.ptr;
          a.status = ST_UNTAGGED;
        end else if (!ok) a.status = ST_RANGE;
        else if (!busy[s]) a.status = ST_NOT_INUSE;
        else begin
          busy[s] = 0;
          link_of[s] = head;
          head = s;
        end
      end
      OP_REALLOC: begin
        a.ptr = {16'h0, r.base};
        if (tag == 0) a.status = ST_UNTAGGED;
        else if (!ok) begin
          a.ptr = addr;
          a.status = ST_RANGE;
        end else if (!busy[s]) a.status = ST_NOT_INUSE;
        else begin
          a.mism = {16'h0, rec_base[s]} != addr;
          rec_base[s] = r.base;
          rec_len[s] = r.size;
          a.ptr = {16'(s + 1), r.base};
        end
      end
      default: begin
        a.ptr = addr;
        if (tag == 0) begin
          a.ptr = r.ptr;
          a.status = ST_UNTAGGED;
        end else if (!ok) a.status = ST_RANGE;
        else begin
          lim = {16'h0, rec_base[s]} + {16'h0, rec_len[s]};
          a.inb = addr >= {16'h0, rec_base[s]} && addr < lim;
        end
      end
    endcase
    return a;
  endfunction

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_tagged_pointer_bounds_table NOT OK");
    $finish;
  end

  // sender side: drive at the falling edge; hold while offered and not yet taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && !in_ready_q)) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          request_t r;
          r = pending_words.pop_front();
          in_valid <= 1;
          opcode <= r.op;
          tagged_pointer <= r.ptr;
          new_base <= r.base;
          object_size <= r.size;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= hold_off > 0 ? 1'b0 : $urandom_range(99) >= recv_stall;
    end
  end

  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready;
    if (in_valid && in_ready) expected_answers.push_back(
        table_step('{op: opcode_t'(opcode), ptr: tagged_pointer, base: new_base,
                     size: object_size}));
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      answer_t e;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result ptr=%h status=%0d", $realtime,
                 result_pointer, status_code);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (e.ptr !== result_pointer || e.status !== status_code ||
            e.inb !== in_bounds || e.mism !== base_mismatch) begin
          $display("%0t: mismatch exp ptr=%h st=%0d inb=%0b mism=%0b", $realtime,
                   e.ptr, e.status, e.inb, e.mism);
          $display("%0t:          got ptr=%h st=%0d inb=%0b mism=%0b", $realtime,
                   result_pointer, status_code, in_bounds, base_mismatch);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] pick_size();
    case ($urandom_range(3))
      0: return '0;
      1: return 48'hFFFF_FFFF_FFFF;
      default: return 48'($urandom_range(4096));
    endcase
  endfunction

  task automatic queue_word(opcode_t op, logic [63:0] p, logic [47:0] b, logic [47:0] z);
    pending_words.push_back('{op: op, ptr: p, base: b, size: z});
  endtask

  // generator keeps its own notion of which tags are live to aim at valid slots
  int unsigned gen_head;
  int unsigned gen_link [NSLOTS];
  bit gen_busy [NSLOTS];
  bit gen_written [NSLOTS];
  logic [47:0] gen_base [NSLOTS];

  task automatic gen_word(opcode_t op, logic [63:0] p, logic [47:0] b, logic [47:0] z);
    logic [63:0] tag;
    int unsigned s;
    tag = p >> TSHIFT;
    s = 32'(tag - 1);
    // never check a slot that was never written
    if (op == OP_CHECK && tag >= 1 && tag <= NSLOTS && !gen_written[s])
      return;
    case (op)
      OP_ALLOC: if (gen_head < NSLOTS) begin
        s = gen_head;
        gen_head = gen_link[s];
        gen_busy[s] = 1;
        gen_written[s] = 1;
        gen_base[s] = b;
      end
      OP_FREE: if (tag >= 1 && tag <= NSLOTS && gen_busy[s]) begin
        gen_busy[s] = 0;
        gen_link[s] = gen_head;
        gen_head = s;
      end
      OP_REALLOC: if (tag >= 1 && tag <= NSLOTS && gen_busy[s]) gen_base[s] = b;
      default: ;
    endcase
    queue_word(op, p, b, z);
  endtask

  function automatic logic [63:0] some_written_ptr(bit want_busy);
    int unsigned s;
    for (int k = 0; k < 64; k++) begin
      s = $urandom_range(NSLOTS - 1);
      if (gen_written[s] && (!want_busy || gen_busy[s]))
        return {16'(s + 1), gen_base[s]};
    end
    return {16'(gen_head < NSLOTS ? 0 : 1), 48'h0};
  endfunction

  task automatic gen_random();
    logic [63:0] p;
    logic [47:0] b;
    int unsigned pick;
    pick = $urandom_range(99);
    b = rnd48();
    p = some_written_ptr(1);
    if (pick < 30) gen_word(OP_ALLOC, rnd64(), b, pick_size());
    else if (pick < 50) gen_word(OP_FREE, p, b, '0);
    else if (pick < 62) gen_word(OP_REALLOC,
        $urandom_range(1) ? p : {p[63:48], rnd48()}, b, pick_size());
    else if (pick < 85) begin
      p = some_written_ptr(0);
      if (p[63:48] != 0)
        p[47:0] = gen_base[p[63:48] - 1] + 48'($urandom_range(4200)) - 48'd50;
      gen_word(OP_CHECK, p, b, '0);
    end else begin
      // noise: untagged, out of range, stale or random tags
      p = rnd64();
      case ($urandom_range(3))
        0: p[63:48] = 0;
        1: p[63:48] = 16'($urandom_range(NSLOTS + 1, 16'hFFFF));
        default: p[63:48] = 16'($urandom_range(1, NSLOTS));
      endcase
      gen_word(opcode_t'($urandom_range(3)), p, b, pick_size());
    end
  endtask

  task automatic drain(int extra);
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      link_of[i] = i + 1;
      busy[i] = 0;
      written[i] = 0;
      rec_base[i] = '0;
      rec_len[i] = '0;
      gen_link[i] = i + 1;
      gen_busy[i] = 0;
      gen_written[i] = 0;
      gen_base[i] = '0;
    end
    head = 0;
    gen_head = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: each special case and field extremes
    gen_word(OP_ALLOC, '0, 48'hFFFF_FFFF_FFFF, 48'h1);
    gen_word(OP_ALLOC, '1, 48'h0, 48'hFFFF_FFFF_FFFF);
    gen_word(OP_CHECK, {16'd1, 48'hFFFF_FFFF_FFFF}, '0, '0);
    gen_word(OP_CHECK, {16'd1, 48'hFFFF_FFFF_FFFE}, '0, '0);
    gen_word(OP_CHECK, {16'd2, 48'h8000_0000_0000}, '0, '0);
    gen_word(OP_CHECK, 64'h0000_8000_0000_1234, '0, '0);
    gen_word(OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    gen_word(OP_CHECK, {16'd257, 48'h8000_0000_0000}, '0, '0);
    gen_word(OP_FREE, 64'h0000_0000_0000_0042, '0, '0);
    gen_word(OP_FREE, {16'd257, 48'h1}, '0, '0);
    gen_word(OP_FREE, {16'd200, 48'h1}, '0, '0);
    gen_word(OP_REALLOC, {16'd200, 48'h1}, 48'h5, 48'h5);
    gen_word(OP_REALLOC, 64'h0000_0000_0000_0001, 48'h7, 48'h7);
    gen_word(OP_REALLOC, {16'hFFFF, 48'h7}, 48'h7, 48'h7);
    gen_word(OP_REALLOC, {16'd1, 48'hFFFF_FFFF_FFFF}, 48'h100, 48'h10);
    gen_word(OP_REALLOC, {16'd2, 48'h1}, 48'h200, 48'h10);
    gen_word(OP_FREE, {16'd1, 48'h100}, '0, '0);
    gen_word(OP_FREE, {16'd1, 48'h100}, '0, '0);
    gen_word(OP_CHECK, {16'd1, 48'h100}, '0, '0);
    // fill the table then overflow it
    for (int i = 0; i < NSLOTS + 2; i++) gen_word(OP_ALLOC, '0, rnd48(), pick_size());
    drain(10);

    // random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 67; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 67; end
        3: begin send_idle = 17; recv_stall = 17; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) hold_off = 300;
      for (int i = 0; i < 250; i++) gen_random();
      drain(10);
    end
    if (errors == 0) $display("tb_tagged_pointer_bounds_table OK");
    else $display("tb_tagged_pointer_bounds_table NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
